// ===== sv/lgf_pkg.sv =====
// shared types and constants of the linear gradient fill generator
`default_nettype none

package lgf_pkg;

    localparam int MAX_SIZE_DEF = 2048;

    localparam int CH_W     = 8;
    localparam int COORD_W  = 13;
    localparam int TDATA_W  = 72;
    localparam int IN_W     = 8;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    // register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_COLOR_START = 3'd0;
    localparam logic [2:0] REG_COLOR_END   = 3'd1;
    localparam logic [2:0] REG_ORIGIN_X    = 3'd2;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd3;
    localparam logic [2:0] REG_FILL_WIDTH  = 3'd4;
    localparam logic [2:0] REG_FILL_HEIGHT = 3'd5;
    localparam logic [2:0] REG_DIRECTION   = 3'd6;
    localparam logic [2:0] REG_BLEND_MODE  = 3'd7;

    typedef struct packed {
        logic [31:0] color_start;
        logic [31:0] color_end;
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [11:0] fill_width;
        logic [11:0] fill_height;
        logic        direction;
        logic [7:0]  blend_mode;
    } t_cfg;

endpackage

`default_nettype wire

// ===== sv/lgf_regs.sv =====
// apb register file holding the fill setup
`default_nettype none

module lgf_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lgf_pkg::APB_AW-1:0] paddr,
    input  wire logic [lgf_pkg::APB_DW-1:0] pwdata,
    output logic      [lgf_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output lgf_pkg::t_cfg                   o_cfg
);

    lgf_pkg::t_cfg r_cfg;
    logic          w_wr;
    logic [2:0]    w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[4:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_start <= '0;
            r_cfg.color_end   <= '0;
            r_cfg.origin_x    <= '0;
            r_cfg.origin_y    <= '0;
            r_cfg.fill_width  <= 12'd1;
            r_cfg.fill_height <= 12'd1;
            r_cfg.direction   <= 1'b0;
            r_cfg.blend_mode  <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                lgf_pkg::REG_COLOR_START: r_cfg.color_start <= pwdata;
                lgf_pkg::REG_COLOR_END:   r_cfg.color_end   <= pwdata;
                lgf_pkg::REG_ORIGIN_X:    r_cfg.origin_x    <= pwdata[11:0];
                lgf_pkg::REG_ORIGIN_Y:    r_cfg.origin_y    <= pwdata[11:0];
                lgf_pkg::REG_FILL_WIDTH:  r_cfg.fill_width  <= pwdata[11:0];
                lgf_pkg::REG_FILL_HEIGHT: r_cfg.fill_height <= pwdata[11:0];
                lgf_pkg::REG_DIRECTION:   r_cfg.direction   <= pwdata[0];
                lgf_pkg::REG_BLEND_MODE:  r_cfg.blend_mode  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            lgf_pkg::REG_COLOR_START: prdata = r_cfg.color_start;
            lgf_pkg::REG_COLOR_END:   prdata = r_cfg.color_end;
            lgf_pkg::REG_ORIGIN_X:    prdata = {20'd0, r_cfg.origin_x};
            lgf_pkg::REG_ORIGIN_Y:    prdata = {20'd0, r_cfg.origin_y};
            lgf_pkg::REG_FILL_WIDTH:  prdata = {20'd0, r_cfg.fill_width};
            lgf_pkg::REG_FILL_HEIGHT: prdata = {20'd0, r_cfg.fill_height};
            lgf_pkg::REG_DIRECTION:   prdata = {31'd0, r_cfg.direction};
            lgf_pkg::REG_BLEND_MODE:  prdata = {24'd0, r_cfg.blend_mode};
            default:                  prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/lgf_lerp.sv =====
// shared channel interpolator: one multiply, then a bit-serial restoring divide
`default_nettype none

module lgf_lerp #(
    parameter int MAX_SIZE = lgf_pkg::MAX_SIZE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [lgf_pkg::CH_W-1:0]      i_c1,
    input  wire logic [lgf_pkg::CH_W-1:0]      i_c2,
    input  wire logic [$clog2(MAX_SIZE)-1:0]   i_k,
    input  wire logic [$clog2(MAX_SIZE+1)-1:0] i_ext,
    output logic                               o_done,
    output logic      [lgf_pkg::CH_W-1:0]      o_result
);

    localparam int IDXW = $clog2(MAX_SIZE);
    localparam int EXTW = $clog2(MAX_SIZE + 1);
    localparam int CW   = EXTW + lgf_pkg::CH_W;
    localparam int PW   = lgf_pkg::CH_W + IDXW;

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_MUL  = 2'd1;
    localparam logic [1:0] L_DIV  = 2'd2;
    localparam logic [1:0] L_DONE = 2'd3;

    logic [1:0]              r_state;
    logic [2:0]              r_bit;
    logic                    r_neg;
    logic [lgf_pkg::CH_W-1:0] r_c1;
    logic [lgf_pkg::CH_W-1:0] r_mag;
    logic [IDXW-1:0]         r_k;
    logic [EXTW-1:0]         r_ext;
    logic [CW-1:0]           r_rem;
    logic [CW-1:0]           r_den;
    logic [lgf_pkg::CH_W-1:0] r_q;
    logic [PW-1:0]           w_prod;
    logic                    w_neg;

    assign w_neg  = i_c2 < i_c1;
    assign w_prod = r_mag * r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_bit   <= '0;
        end else begin
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_state <= L_MUL;
                    end
                end
                L_MUL: begin
                    r_state <= L_DIV;
                    r_bit   <= '0;
                end
                L_DIV: begin
                    r_bit <= r_bit + 3'd1;
                    if (r_bit == 3'd7) begin
                        r_state <= L_DONE;
                    end
                end
                L_DONE:  r_state <= L_IDLE;
                default: r_state <= L_IDLE;
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == L_IDLE && i_start) begin
            r_neg <= w_neg;
            r_c1  <= i_c1;
            r_mag <= w_neg ? (i_c1 - i_c2) : (i_c2 - i_c1);
            r_k   <= i_k;
            r_ext <= i_ext;
        end
        if (r_state == L_MUL) begin
            r_rem <= CW'(w_prod);
            r_den <= CW'({r_ext, 7'd0});
            r_q   <= '0;
        end
        if (r_state == L_DIV) begin
            if (r_rem >= r_den) begin
                r_rem <= r_rem - r_den;
                r_q   <= {r_q[lgf_pkg::CH_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[lgf_pkg::CH_W-2:0], 1'b0};
            end
            r_den <= r_den >> 1;
        end
    end

    assign o_done   = (r_state == L_DONE);
    assign o_result = r_neg ? (r_c1 - r_q) : (r_c1 + r_q);

endmodule

`default_nettype wire

// ===== sv/linear_gradient_fill_generator.sv =====
// top level of the linear gradient rectangle fill generator
//
// usage: program colors, origin, size, direction and blend mode over the apb
// port while the block is idle. each transfer on the input stream (tdata
// bit 0 = restart) yields exactly one pixel transfer on the output stream:
// tdata carries x, y, argb channels and the draw mode, tlast marks the final
// pixel of the rectangle. restart = 1 begins a new fill; after the final
// pixel the scan wraps to the first one by itself.
// vertical gradients scan row by row, horizontal ones column by column.
// a pixel inside a line passes from the accepting idle step to the emit
// step and from there into the output register; a pixel that opens a line
// first recomputes the line color, four channels in turn in the shared
// multiply and bit-serial divide unit. one item is in work at a time: a new
// input is taken only after the current pixel has left the emit step.
// the output register decouples the sides: a new input is taken while a
// finished pixel still waits; a stalled receiver holds the next pixel in
// the emit step and input ready stays low until the register frees up.
// reset (synchronous, active low) restores the register defaults (size 1x1)
// and returns the scan to the first pixel.
`default_nettype none

module linear_gradient_fill_generator #(
    parameter int MAX_SIZE = lgf_pkg::MAX_SIZE_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input stream
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire logic [lgf_pkg::IN_W-1:0]    i_s_axis_tdata,  // [0] restart, rest zero
    // output stream
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    // [12:0] pixel_x, [25:13] pixel_y, [33:26] alpha, [41:34] red,
    // [49:42] green, [57:50] blue, [65:58] draw_mode, [71:66] zero
    output logic      [lgf_pkg::TDATA_W-1:0] o_m_axis_tdata,
    output logic                             o_m_axis_tlast,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lgf_pkg::APB_AW-1:0]  paddr,
    input  wire logic [lgf_pkg::APB_DW-1:0]  pwdata,
    output logic      [lgf_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);

    localparam int IDXW = $clog2(MAX_SIZE);
    localparam int EXTW = $clog2(MAX_SIZE + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    lgf_pkg::t_cfg w_cfg;

    logic [1:0]      r_state;
    logic [IDXW-1:0] r_col;
    logic [IDXW-1:0] r_row;
    logic [31:0]     r_line_color;
    logic [1:0]      r_chan;
    logic            r_lerp_start;
    logic            r_out_valid;
    logic            r_out_last;
    logic [lgf_pkg::TDATA_W-1:0] r_out_data;

    logic [EXTW-1:0] w_w;
    logic [EXTW-1:0] w_h;
    logic            w_horiz;
    logic            w_accept;
    logic            w_rescan;
    logic [IDXW-1:0] n_col;
    logic [IDXW-1:0] n_row;
    logic            w_need_color;
    logic            w_load;
    logic            w_last;
    logic [lgf_pkg::COORD_W-1:0] w_px;
    logic [lgf_pkg::COORD_W-1:0] w_py;
    logic            w_lerp_done;
    logic [7:0]      w_lerp_res;
    logic [7:0]      w_c1;
    logic [7:0]      w_c2;
    logic [IDXW-1:0] w_k;
    logic [EXTW-1:0] w_ext;

    lgf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // extents clamped to 1..MAX_SIZE
    always_comb begin
        if (w_cfg.fill_width == 12'd0) begin
            w_w = EXTW'(1);
        end else if (32'(w_cfg.fill_width) > 32'(MAX_SIZE)) begin
            w_w = EXTW'(MAX_SIZE);
        end else begin
            w_w = EXTW'(w_cfg.fill_width);
        end
        if (w_cfg.fill_height == 12'd0) begin
            w_h = EXTW'(1);
        end else if (32'(w_cfg.fill_height) > 32'(MAX_SIZE)) begin
            w_h = EXTW'(MAX_SIZE);
        end else begin
            w_h = EXTW'(w_cfg.fill_height);
        end
    end

    assign w_horiz  = w_cfg.direction;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept = i_s_axis_tvalid & o_s_axis_tready;

    // restart request, or the scan fell outside a shrunken rectangle
    assign w_rescan = i_s_axis_tdata[0] | (EXTW'(r_col) >= w_w) | (EXTW'(r_row) >= w_h);
    assign n_col    = w_rescan ? '0 : r_col;
    assign n_row    = w_rescan ? '0 : r_row;
    // line color is refreshed on the first pixel of each line
    assign w_need_color = w_horiz ? (n_row == '0) : (n_col == '0);

    // shared interpolator operands
    assign w_c1  = w_cfg.color_start[8*r_chan +: 8];
    assign w_c2  = w_cfg.color_end[8*r_chan +: 8];
    assign w_k   = w_horiz ? r_col : r_row;
    assign w_ext = w_horiz ? w_w : w_h;

    lgf_lerp #(
        .MAX_SIZE (MAX_SIZE)
    ) u_lerp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_lerp_start),
        .i_c1     (w_c1),
        .i_c2     (w_c2),
        .i_k      (w_k),
        .i_ext    (w_ext),
        .o_done   (w_lerp_done),
        .o_result (w_lerp_res)
    );

    // pixel fields
    assign w_load = (r_state == ST_EMIT) & (~r_out_valid | i_m_axis_tready);
    assign w_last = (EXTW'(r_col) == w_w - EXTW'(1)) & (EXTW'(r_row) == w_h - EXTW'(1));
    assign w_px   = {w_cfg.origin_x[11], w_cfg.origin_x} + lgf_pkg::COORD_W'(r_col);
    assign w_py   = {w_cfg.origin_y[11], w_cfg.origin_y} + lgf_pkg::COORD_W'(r_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_col        <= '0;
            r_row        <= '0;
            r_line_color <= '0;
            r_chan       <= '0;
            r_lerp_start <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_lerp_start <= 1'b0;
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_col  <= n_col;
                        r_row  <= n_row;
                        r_chan <= '0;
                        if (w_need_color) begin
                            r_state      <= ST_CALC;
                            r_lerp_start <= 1'b1;
                        end else begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_CALC: begin
                    if (w_lerp_done) begin
                        r_line_color[8*r_chan +: 8] <= w_lerp_res;
                        if (r_chan == 2'd3) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_chan       <= r_chan + 2'd1;
                            r_lerp_start <= 1'b1;
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_load) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                        // advance the scan
                        if (w_last) begin
                            r_col <= '0;
                            r_row <= '0;
                        end else if (w_horiz) begin
                            if (EXTW'(r_row) + EXTW'(1) >= w_h) begin
                                r_row <= '0;
                                r_col <= r_col + IDXW'(1);
                            end else begin
                                r_row <= r_row + IDXW'(1);
                            end
                        end else begin
                            if (EXTW'(r_col) + EXTW'(1) >= w_w) begin
                                r_col <= '0;
                                r_row <= r_row + IDXW'(1);
                            end else begin
                                r_col <= r_col + IDXW'(1);
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= {6'd0, w_cfg.blend_mode, r_line_color[7:0], r_line_color[15:8],
                           r_line_color[23:16], r_line_color[31:24], w_py, w_px};
            r_out_last <= w_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // the interpolator only runs while a line color is being built
    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lerp_done |-> (r_state == ST_CALC))
        else $error("interpolator finished outside color calculation");

    a_start_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lerp_start |-> (r_state == ST_CALC))
        else $error("interpolator started outside color calculation");

    // a restart transfer always begins at the first pixel
    a_restart_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_axis_tdata[0]) |=> (r_col == '0 && r_row == '0))
        else $error("restart did not return scan to first pixel");

    // the final pixel wraps the scan
    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> (r_col == '0 && r_row == '0))
        else $error("scan did not wrap after final pixel");

    // a line color pass ends with all four channels
    a_calc_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC && w_lerp_done && r_chan != 2'd3) |=> r_lerp_start)
        else $error("color pass stopped before the last channel");

endmodule

`default_nettype wire
